@@ rtl/tcm_pkg.sv @@
// Shared types and constants of the touch coordinate mapper.
// Holds the register file layout, register indexes and pipeline sideband.
// Depends on nothing; every other file of the block imports it.
package tcm_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int RAW_W      = 12;
  localparam int MARGIN_W   = 11;
  localparam int SIZE_W     = 12;
  localparam int COORD_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Quotient bits resolved by the divider; larger quotients saturate anyway.
  localparam int QUOT_W = 16;
  // Two independent lanes: x and y.
  localparam int LANES  = 2;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;

  // Defaults for the top-level parameters.
  localparam int PANEL_MIRROR_DEF = 0;
  localparam int RAW_MAX_DEF      = 4095;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROTATION      = 3'd0,
    CFG_REVERSE_MODE  = 3'd1,
    CFG_MARGIN_LEFT   = 3'd2,
    CFG_MARGIN_RIGHT  = 3'd3,
    CFG_MARGIN_TOP    = 3'd4,
    CFG_MARGIN_BOTTOM = 3'd5,
    CFG_SCREEN_WIDTH  = 3'd6,
    CFG_SCREEN_HEIGHT = 3'd7
  } cfg_idx_e;

  // Display rotations.
  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef struct packed {
    logic [1:0]          rotation;
    logic                reverse_mode;
    logic [MARGIN_W-1:0] margin_left;
    logic [MARGIN_W-1:0] margin_right;
    logic [MARGIN_W-1:0] margin_top;
    logic [MARGIN_W-1:0] margin_bottom;
    logic [SIZE_W-1:0]   screen_width;
    logic [SIZE_W-1:0]   screen_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    rotation:      2'd0,
    reverse_mode:  1'b0,
    margin_left:   11'd0,
    margin_right:  11'd0,
    margin_top:    11'd0,
    margin_bottom: 11'd0,
    screen_width:  12'd320,
    screen_height: 12'd240
  };

  // Per-item flags that ride along the divider pipeline.
  typedef struct packed {
    logic             pressed;
    logic [LANES-1:0] neg;    // quotient sign is negative
    logic [LANES-1:0] dzero;  // zero span, lane result is zero
    logic [LANES-1:0] ovf;    // quotient magnitude needs more than QUOT_W bits
  } side_t;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

endpackage

@@ rtl/tcm_front.sv @@
// Front end of the mapper: axis mirroring, span selection, scaling multiply,
// sign split and range check, in four register stages.
// Depends on tcm_pkg.
module tcm_front import tcm_pkg::*; #(
  parameter int PANEL_MIRROR = PANEL_MIRROR_DEF,
  parameter int RAW_MAX      = RAW_MAX_DEF,
  parameter int DEN_W        = 18,
  parameter int NUM_W        = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_pressed_i,
  input  logic [RAW_W-1:0] in_raw_x_i,
  input  logic [RAW_W-1:0] in_raw_y_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [NUM_W-1:0] out_num_o [LANES],
  output logic [DEN_W-1:0] out_den_o [LANES],
  output side_t            out_side_o
);

  localparam int STAGES = 4;
  localparam int CW     = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;
  localparam logic signed [DEN_W-1:0] RMAX_S = DEN_W'(RAW_MAX);

  logic v_q [STAGES];
  logic en  [STAGES];

  // Stage one: mirrored values and signed spans.
  logic signed [DEN_W-1:0]  num1_d [LANES], num1_q [LANES];
  logic signed [DEN_W-1:0]  den1_d [LANES], den1_q [LANES];
  logic        [SIZE_W-1:0] size1_d [LANES], size1_q [LANES];
  logic                     pr1_q;
  // Stage two: scaled numerator.
  logic signed [NUM_W-1:0]  prod2_q [LANES];
  logic signed [DEN_W-1:0]  den2_q [LANES];
  logic                     pr2_q;
  // Stage three: magnitudes and signs.
  logic        [NUM_W-1:0]  nmag3_q [LANES];
  logic        [DEN_W-1:0]  dmag3_q [LANES];
  side_t                    side3_q;
  // Stage four: overflow check done.
  logic        [NUM_W-1:0]  nmag4_q [LANES];
  logic        [DEN_W-1:0]  dmag4_q [LANES];
  side_t                    side4_d;
  side_t                    side4_q;

  // Each stage moves when it is empty or its successor takes its item.
  always_comb begin
    en[STAGES-1] = ~v_q[STAGES-1] | out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) v_q[k] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Mirror the axes and pick the calibrated span for the effective rotation.
  always_comb begin
    logic signed [DEN_W-1:0] xv, yv, ml, mr, mt, mb;
    logic signed [DEN_W-1:0] xlo, xhi, ylo, yhi;
    logic [1:0]              rot;
    xv  = $signed({{(DEN_W-RAW_W){1'b0}}, in_raw_x_i});
    yv  = $signed({{(DEN_W-RAW_W){1'b0}}, in_raw_y_i});
    ml  = $signed({{(DEN_W-MARGIN_W){1'b0}}, cfg_i.margin_left});
    mr  = $signed({{(DEN_W-MARGIN_W){1'b0}}, cfg_i.margin_right});
    mt  = $signed({{(DEN_W-MARGIN_W){1'b0}}, cfg_i.margin_top});
    mb  = $signed({{(DEN_W-MARGIN_W){1'b0}}, cfg_i.margin_bottom});
    rot = cfg_i.rotation;
    if (PANEL_MIRROR != 0) begin
      xv = RMAX_S - xv;
      if (!rot[0]) rot = rot + 2'd2;
    end
    // The reverse setting mirrors x on even rotations and y on odd ones.
    if (cfg_i.reverse_mode && !rot[0]) xv = RMAX_S - xv;
    if (cfg_i.reverse_mode && rot[0])  yv = RMAX_S - yv;
    unique case (rot_e'(rot))
      ROT_0: begin
        xlo = mr; xhi = RMAX_S - ml; ylo = mb; yhi = RMAX_S - mt;
      end
      ROT_90: begin
        xlo = mb; xhi = RMAX_S - mt; ylo = ml; yhi = RMAX_S - mr;
      end
      ROT_180: begin
        xlo = ml; xhi = RMAX_S - mr; ylo = mt; yhi = RMAX_S - mb;
      end
      default: begin
        xlo = mt; xhi = RMAX_S - mb; ylo = mr; yhi = RMAX_S - ml;
      end
    endcase
    num1_d[LANE_X]  = xv - xlo;
    den1_d[LANE_X]  = xhi - xlo;
    size1_d[LANE_X] = cfg_i.screen_width;
    num1_d[LANE_Y]  = yv - ylo;
    den1_d[LANE_Y]  = yhi - ylo;
    size1_d[LANE_Y] = cfg_i.screen_height;
  end

  // A dividend at or above the divisor shifted by QUOT_W saturates.
  always_comb begin
    side4_d = side3_q;
    for (int l = 0; l < LANES; l++) begin
      side4_d.ovf[l] = CW'(nmag3_q[l]) >= (CW'(dmag3_q[l]) << QUOT_W);
    end
  end

  // Payload registers of all four stages.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      num1_q  <= num1_d;
      den1_q  <= den1_d;
      size1_q <= size1_d;
      pr1_q   <= in_pressed_i;
    end
    if (en[1]) begin
      for (int l = 0; l < LANES; l++) begin
        prod2_q[l] <= NUM_W'(num1_q[l]) * $signed({{(NUM_W-SIZE_W){1'b0}}, size1_q[l]});
        den2_q[l]  <= den1_q[l];
      end
      pr2_q <= pr1_q;
    end
    if (en[2]) begin
      for (int l = 0; l < LANES; l++) begin
        nmag3_q[l]       <= prod2_q[l][NUM_W-1] ? NUM_W'(-prod2_q[l]) : NUM_W'(prod2_q[l]);
        dmag3_q[l]       <= den2_q[l][DEN_W-1] ? DEN_W'(-den2_q[l]) : DEN_W'(den2_q[l]);
        side3_q.neg[l]   <= prod2_q[l][NUM_W-1] ^ den2_q[l][DEN_W-1];
        side3_q.dzero[l] <= (den2_q[l] == '0);
        side3_q.ovf[l]   <= 1'b0;
      end
      side3_q.pressed <= pr2_q;
    end
    if (en[3]) begin
      nmag4_q <= nmag3_q;
      dmag4_q <= dmag3_q;
      side4_q <= side4_d;
    end
  end

  assign out_valid_o = v_q[STAGES-1];
  assign out_num_o   = nmag4_q;
  assign out_den_o   = dmag4_q;
  assign out_side_o  = side4_q;

endmodule

@@ rtl/tcm_divider.sv @@
// Pipelined restoring divider for the x and y lanes, one quotient bit per stage.
// Resolves QUOT_W quotient bits of unsigned magnitudes; sideband rides along.
// Depends on tcm_pkg.
module tcm_divider import tcm_pkg::*; #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [NUM_W-1:0]  in_num_i [LANES],
  input  logic [DEN_W-1:0]  in_den_i [LANES],
  input  side_t             in_side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [QUOT_W-1:0] out_quot_o [LANES],
  output side_t             out_side_o
);

  localparam int CW = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;

  logic              v_q   [QUOT_W];
  logic              en    [QUOT_W];
  logic [NUM_W-1:0]  rem_q [QUOT_W][LANES];
  logic [DEN_W-1:0]  dv_q  [QUOT_W][LANES];
  logic [QUOT_W-1:0] quo_q [QUOT_W][LANES];
  side_t             side_q[QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    localparam int BIT = QUOT_W - 1 - k;

    logic              v_in, en_next;
    logic [NUM_W-1:0]  rem_in [LANES], rem_d [LANES];
    logic [DEN_W-1:0]  dv_in  [LANES];
    logic [QUOT_W-1:0] quo_in [LANES], quo_d [LANES];
    side_t             side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = in_num_i;
      assign dv_in   = in_den_i;
      assign quo_in  = '{default: '0};
      assign side_in = in_side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dv_in   = dv_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    if (k == QUOT_W - 1) begin : g_last
      assign en_next = out_ready_i;
    end else begin : g_mid
      assign en_next = en[k+1];
    end

    // The stage moves when it is empty or the next stage takes its item.
    assign en[k] = ~v_q[k] | en_next;

    // Trial subtraction of the divisor aligned to this quotient bit.
    always_comb begin
      logic [CW-1:0] dsh, rext;
      for (int l = 0; l < LANES; l++) begin
        dsh = CW'(dv_in[l]) << BIT;
        rext = CW'(rem_in[l]);
        rem_d[l] = rem_in[l];
        quo_d[l] = quo_in[l];
        if (rext >= dsh) begin
          rem_d[l]      = NUM_W'(rext - dsh);
          quo_d[l][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k]  <= rem_d;
        dv_q[k]   <= dv_in;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[QUOT_W-1];
  assign out_quot_o  = quo_q[QUOT_W-1];
  assign out_side_o  = side_q[QUOT_W-1];

`ifndef SYNTHESIS
  // A finished in-range division leaves a remainder below the divisor.
  a_rem_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QUOT_W-1] && !side_q[QUOT_W-1].dzero[LANE_X] && !side_q[QUOT_W-1].ovf[LANE_X]
    |-> CW'(rem_q[QUOT_W-1][LANE_X]) < CW'(dv_q[QUOT_W-1][LANE_X]))
    else $error("x lane remainder not below divisor");

  a_rem_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QUOT_W-1] && !side_q[QUOT_W-1].dzero[LANE_Y] && !side_q[QUOT_W-1].ovf[LANE_Y]
    |-> CW'(rem_q[QUOT_W-1][LANE_Y]) < CW'(dv_q[QUOT_W-1][LANE_Y]))
    else $error("y lane remainder not below divisor");

  // The divider refuses an item only when every stage is full and stalled.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("divider refused an item with room left");
`endif

endmodule

@@ rtl/touch_coordinate_mapper.sv @@
// Top level of the touch coordinate mapper: register file, front end,
// divider pipeline and the saturating output register.
// Depends on tcm_pkg, tcm_front and tcm_divider.
//
//   Port group      Dir   Contents
//   s_axis_*        in    raw touch sample: pressed in tuser, raw_x and raw_y in tdata
//   m_axis_*        out   mapped point: hit in tuser, screen_x and screen_y in tdata
//   cfg_*           in    register writes, index and data, always ready
//
// One item is accepted per cycle while the output is not stalled; the path runs
// through four front stages (mirror and span, multiply, magnitude, range check),
// sixteen divider stages with one quotient bit each, and the output register.
// Reset clears only valid bits and the registers to their defaults.
// A stalled output holds each stage in place; empty stages ahead of a stall
// still fill, so input is taken until the whole pipeline is full.
module touch_coordinate_mapper import tcm_pkg::*; #(
  parameter int PANEL_MIRROR = PANEL_MIRROR_DEF,
  parameter int RAW_MAX      = RAW_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*RAW_W-1:0]    s_axis_tdata,   // raw_x [11:0], raw_y [23:12]
  input  logic                  s_axis_tuser,   // pressed [0]
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*COORD_W-1:0]  m_axis_tdata,   // screen_x [15:0], screen_y [31:16]
  output logic                  m_axis_tuser,   // hit [0]
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RW    = $clog2(RAW_MAX + 1);
  localparam int DEN_W = ((RW > 13) ? RW : 13) + 2;
  localparam int NUM_W = DEN_W + SIZE_W + 1;

  cfg_t cfg_q;

  logic              fr_valid, fr_ready;
  logic [NUM_W-1:0]  fr_num [LANES];
  logic [DEN_W-1:0]  fr_den [LANES];
  side_t             fr_side;

  logic              dv_valid, dv_ready;
  logic [QUOT_W-1:0] dv_quot [LANES];
  side_t             dv_side;

  logic                      out_v_q, out_en;
  logic                      hit_q, hit_d;
  logic signed [COORD_W-1:0] coord_q [LANES], coord_d [LANES];

  // Register file; writes must arrive only while the pipeline is idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROTATION:      cfg_q.rotation      <= cfg_data_i[1:0];
        CFG_REVERSE_MODE:  cfg_q.reverse_mode  <= cfg_data_i[0];
        CFG_MARGIN_LEFT:   cfg_q.margin_left   <= cfg_data_i[MARGIN_W-1:0];
        CFG_MARGIN_RIGHT:  cfg_q.margin_right  <= cfg_data_i[MARGIN_W-1:0];
        CFG_MARGIN_TOP:    cfg_q.margin_top    <= cfg_data_i[MARGIN_W-1:0];
        CFG_MARGIN_BOTTOM: cfg_q.margin_bottom <= cfg_data_i[MARGIN_W-1:0];
        CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[SIZE_W-1:0];
        CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  tcm_front #(
    .PANEL_MIRROR (PANEL_MIRROR),
    .RAW_MAX      (RAW_MAX),
    .DEN_W        (DEN_W),
    .NUM_W        (NUM_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_pressed_i (s_axis_tuser),
    .in_raw_x_i   (s_axis_tdata[RAW_W-1:0]),
    .in_raw_y_i   (s_axis_tdata[2*RAW_W-1:RAW_W]),
    .out_valid_o  (fr_valid),
    .out_ready_i  (fr_ready),
    .out_num_o    (fr_num),
    .out_den_o    (fr_den),
    .out_side_o   (fr_side)
  );

  tcm_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_num_i    (fr_num),
    .in_den_i    (fr_den),
    .in_side_i   (fr_side),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .out_quot_o  (dv_quot),
    .out_side_o  (dv_side)
  );

  // Apply the sign and saturate each lane to 16 bits.
  always_comb begin
    hit_d = dv_side.pressed;
    for (int l = 0; l < LANES; l++) begin
      if (!dv_side.pressed || dv_side.dzero[l]) begin
        coord_d[l] = '0;
      end else if (dv_side.ovf[l]) begin
        coord_d[l] = dv_side.neg[l] ? COORD_MIN : COORD_MAX;
      end else if (!dv_side.neg[l]) begin
        coord_d[l] = dv_quot[l][QUOT_W-1] ? COORD_MAX : $signed(dv_quot[l]);
      end else if (dv_quot[l][QUOT_W-1] && (dv_quot[l][QUOT_W-2:0] != '0)) begin
        coord_d[l] = COORD_MIN;
      end else begin
        coord_d[l] = COORD_W'(-$signed({1'b0, dv_quot[l]}));
      end
    end
  end

  // Output register.
  assign out_en   = ~out_v_q | m_axis_tready;
  assign dv_ready = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      hit_q   <= hit_d;
      coord_q <= coord_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = hit_q;
  assign m_axis_tdata  = {coord_q[LANE_Y], coord_q[LANE_X]};

`ifndef SYNTHESIS
  // An unpressed sample always reports the origin.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("unpressed item carries nonzero coordinates");

  // A rotation write lands in the register file on the next cycle.
  a_cfg_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_ROTATION)
    |=> cfg_q.rotation == $past(cfg_data_i[1:0]))
    else $error("rotation write lost");

  // With the output register empty nothing can hold back the input.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");
`endif

endmodule

@@ dv/tb_touch_coordinate_mapper.sv @@
// Self-checking testbench of the touch coordinate mapper: streams raw touch samples,
// predicts each mapped point in step with the register settings and checks the output.
// Depends on tcm_pkg and touch_coordinate_mapper.
`timescale 1ns / 100ps

module tb_touch_coordinate_mapper;
  import tcm_pkg::*;

  localparam int PANEL_MIRROR = PANEL_MIRROR_DEF;
  localparam int RAW_MAX      = RAW_MAX_DEF;
  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT  = 3000;
  // Output register hold used to back the pipeline up into the input.
  localparam int LONG_HOLD    = 400;
  // Drain time after the last result, longer than the pipeline latency.
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic              pressed;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
  } touch_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
  } point_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*RAW_W-1:0]    s_axis_tdata = '0;   // raw_x [11:0], raw_y [23:12]
  logic                  s_axis_tuser = 1'b0; // pressed [0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*COORD_W-1:0]  m_axis_tdata;        // screen_x [15:0], screen_y [31:16]
  logic                  m_axis_tuser;        // hit [0]
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  touch_t touch_backlog[$];
  point_t expected_points[$];
  cfg_t   panel_cfg = CFG_RESET;

  int error_count = 0;
  int quiet_cycles = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int sink_hold_left = 0;
  bit src_idle_on = 1'b0;
  bit sink_idle_on = 1'b0;

  touch_t accepted_touch;
  point_t expected_point;
  point_t actual_point;

  touch_coordinate_mapper #(
    .PANEL_MIRROR(PANEL_MIRROR),
    .RAW_MAX     (RAW_MAX)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Linear map of one axis onto its screen span, truncated toward zero and saturated.
  function automatic logic signed [COORD_W-1:0] scale_axis(longint v, longint lo,
                                                           longint hi, longint span);
    longint den;
    longint q;
    den = hi - lo;
    if (den == 0) return '0;
    q = ((v - lo) * span) / den;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[COORD_W-1:0];
  endfunction

  // Expected mapped point of one touch sample under the given settings.
  function automatic point_t map_touch(touch_t t, cfg_t c);
    point_t p;
    longint x, y, ml, mr, mt, mb;
    longint xlo, xhi, ylo, yhi;
    logic [1:0] rot;
    p = '0;
    if (!t.pressed) return p;
    x   = longint'(t.raw_x);
    y   = longint'(t.raw_y);
    ml  = longint'(c.margin_left);
    mr  = longint'(c.margin_right);
    mt  = longint'(c.margin_top);
    mb  = longint'(c.margin_bottom);
    rot = c.rotation;
    // A mirrored panel flips x and turns even rotations half way around.
    if (PANEL_MIRROR != 0) begin
      x = RAW_MAX - x;
      if (!rot[0]) rot = rot + 2'd2;
    end
    case (rot_e'(rot))
      ROT_0: begin
        if (c.reverse_mode) x = RAW_MAX - x;
        xlo = mr; xhi = RAW_MAX - ml;
        ylo = mb; yhi = RAW_MAX - mt;
      end
      ROT_90: begin
        if (c.reverse_mode) y = RAW_MAX - y;
        xlo = mb; xhi = RAW_MAX - mt;
        ylo = ml; yhi = RAW_MAX - mr;
      end
      ROT_180: begin
        if (c.reverse_mode) x = RAW_MAX - x;
        xlo = ml; xhi = RAW_MAX - mr;
        ylo = mt; yhi = RAW_MAX - mb;
      end
      default: begin
        if (c.reverse_mode) y = RAW_MAX - y;
        xlo = mt; xhi = RAW_MAX - mb;
        ylo = mr; yhi = RAW_MAX - ml;
      end
    endcase
    p.hit      = 1'b1;
    p.screen_x = scale_axis(x, xlo, xhi, longint'(c.screen_width));
    p.screen_y = scale_axis(y, ylo, yhi, longint'(c.screen_height));
    return p;
  endfunction

  // Sample driver: predicts each accepted item, then offers the next one from the backlog.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        accepted_touch.pressed = s_axis_tuser;
        accepted_touch.raw_x   = s_axis_tdata[RAW_W-1:0];
        accepted_touch.raw_y   = s_axis_tdata[2*RAW_W-1:RAW_W];
        expected_points.push_back(map_touch(accepted_touch, panel_cfg));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (touch_backlog.size() > 0) begin
          accepted_touch = touch_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= accepted_touch.pressed;
          s_axis_tdata  <= {accepted_touch.raw_y, accepted_touch.raw_x};
          if (src_idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 13);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted point against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        actual_point.hit      = m_axis_tuser;
        actual_point.screen_x = m_axis_tdata[COORD_W-1:0];
        actual_point.screen_y = m_axis_tdata[2*COORD_W-1:COORD_W];
        if (expected_points.size() == 0) begin
          $error("point out with no sample pending: hit %0b x %0d y %0d",
                 actual_point.hit, actual_point.screen_x, actual_point.screen_y);
          error_count++;
        end else begin
          expected_point = expected_points.pop_front();
          if (actual_point.hit !== expected_point.hit) begin
            $error("hit: expected %0b, got %0b", expected_point.hit, actual_point.hit);
            error_count++;
          end
          if (actual_point.screen_x !== expected_point.screen_x) begin
            $error("screen_x: expected %0d, got %0d",
                   expected_point.screen_x, actual_point.screen_x);
            error_count++;
          end
          if (actual_point.screen_y !== expected_point.screen_y) begin
            $error("screen_y: expected %0d, got %0d",
                   expected_point.screen_y, actual_point.screen_y);
            error_count++;
          end
        end
      end
      // A long hold wins over the short random bursts.
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 13);
      end
    end
  end

  // Hang detection: any handshake on any port restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL touch_coordinate_mapper");
      $finish;
    end
  end

  // One register write; the local copy of the settings follows at the handshake.
  task automatic program_reg(cfg_idx_e idx, int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ROTATION:      panel_cfg.rotation      = data[1:0];
      CFG_REVERSE_MODE:  panel_cfg.reverse_mode  = data[0];
      CFG_MARGIN_LEFT:   panel_cfg.margin_left   = data[MARGIN_W-1:0];
      CFG_MARGIN_RIGHT:  panel_cfg.margin_right  = data[MARGIN_W-1:0];
      CFG_MARGIN_TOP:    panel_cfg.margin_top    = data[MARGIN_W-1:0];
      CFG_MARGIN_BOTTOM: panel_cfg.margin_bottom = data[MARGIN_W-1:0];
      CFG_SCREEN_WIDTH:  panel_cfg.screen_width  = data[SIZE_W-1:0];
      default:           panel_cfg.screen_height = data[SIZE_W-1:0];
    endcase
  endtask

  task automatic queue_touch(bit pressed, int x, int y);
    touch_t t;
    t.pressed = pressed;
    t.raw_x   = x[RAW_W-1:0];
    t.raw_y   = y[RAW_W-1:0];
    touch_backlog.push_back(t);
  endtask

  // Waits, sampling away from the active edge, until no sample or point is in flight.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (touch_backlog.size() > 0 || s_axis_tvalid || expected_points.size() > 0);
  endtask

  function automatic int pick_margin();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 2047;
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 4095;
      2:       return $urandom_range(1, 16);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // Raw coordinate biased toward the rails and the calibrated span edges.
  function automatic int pick_coord();
    logic [RAW_W-1:0] v;
    int m;
    case ($urandom_range(0, 3))
      0:       m = int'(panel_cfg.margin_left);
      1:       m = int'(panel_cfg.margin_right);
      2:       m = int'(panel_cfg.margin_top);
      default: m = int'(panel_cfg.margin_bottom);
    endcase
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = RAW_W'(m + $urandom_range(0, 2) - 1);
      3:       v = RAW_W'(RAW_MAX - m + $urandom_range(0, 2) - 1);
      default: v = RAW_W'($urandom_range(0, 4095));
    endcase
    return int'(v);
  endfunction

  // Reset, directed corner cases, then random phases with fresh settings.
  initial begin : stimulus
    int n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default settings: rails and an idle sample.
    queue_touch(1'b0, 4095, 4095);
    queue_touch(1'b1, 0, 0);
    queue_touch(1'b1, 4095, 4095);
    queue_touch(1'b1, 4095, 0);
    queue_touch(1'b1, 2048, 1);
    wait_drained();

    // Widest margins leave a one-unit span, so x saturates both ways; zero height.
    program_reg(CFG_ROTATION, ROT_0);
    program_reg(CFG_REVERSE_MODE, 1);
    program_reg(CFG_MARGIN_LEFT, 2047);
    program_reg(CFG_MARGIN_RIGHT, 2047);
    program_reg(CFG_MARGIN_TOP, 2047);
    program_reg(CFG_MARGIN_BOTTOM, 2047);
    program_reg(CFG_SCREEN_WIDTH, 4095);
    program_reg(CFG_SCREEN_HEIGHT, 0);
    queue_touch(1'b1, 0, 0);
    queue_touch(1'b1, 4095, 4095);
    queue_touch(1'b1, 2048, 2047);
    queue_touch(1'b1, 2047, 2048);
    queue_touch(1'b0, 0, 4095);
    wait_drained();

    // Asymmetric margins under the odd rotations, with and without reverse, then the half turn.
    program_reg(CFG_ROTATION, ROT_270);
    program_reg(CFG_REVERSE_MODE, 0);
    program_reg(CFG_MARGIN_LEFT, 0);
    program_reg(CFG_MARGIN_RIGHT, 2047);
    program_reg(CFG_MARGIN_TOP, 100);
    program_reg(CFG_MARGIN_BOTTOM, 5);
    program_reg(CFG_SCREEN_WIDTH, 0);
    program_reg(CFG_SCREEN_HEIGHT, 4095);
    queue_touch(1'b1, 0, 0);
    queue_touch(1'b1, 4095, 4095);
    queue_touch(1'b1, 2047, 2048);
    wait_drained();
    program_reg(CFG_ROTATION, ROT_90);
    program_reg(CFG_REVERSE_MODE, 1);
    program_reg(CFG_MARGIN_LEFT, 1000);
    program_reg(CFG_MARGIN_RIGHT, 3);
    program_reg(CFG_MARGIN_TOP, 2047);
    program_reg(CFG_MARGIN_BOTTOM, 0);
    program_reg(CFG_SCREEN_WIDTH, 1);
    queue_touch(1'b1, 0, 4095);
    queue_touch(1'b1, 4095, 0);
    queue_touch(1'b1, 1234, 2345);
    wait_drained();
    program_reg(CFG_ROTATION, ROT_180);
    program_reg(CFG_SCREEN_WIDTH, 800);
    program_reg(CFG_SCREEN_HEIGHT, 480);
    queue_touch(1'b1, 10, 4000);
    queue_touch(1'b1, 3000, 50);

    // Random phases; the last ones run without any idling.
    for (int phase = 0; phase < 16; phase++) begin
      wait_drained();
      program_reg(CFG_ROTATION, $urandom_range(0, 3) | ($urandom_range(0, 1023) << 2));
      program_reg(CFG_REVERSE_MODE, $urandom_range(0, 1) | ($urandom_range(0, 2047) << 1));
      if ($urandom_range(0, 2) != 0) program_reg(CFG_MARGIN_LEFT,
                                                 pick_margin() | ($urandom_range(0, 1) << 11));
      if ($urandom_range(0, 2) != 0) program_reg(CFG_MARGIN_RIGHT,
                                                 pick_margin() | ($urandom_range(0, 1) << 11));
      if ($urandom_range(0, 2) != 0) program_reg(CFG_MARGIN_TOP,
                                                 pick_margin() | ($urandom_range(0, 1) << 11));
      if ($urandom_range(0, 2) != 0) program_reg(CFG_MARGIN_BOTTOM,
                                                 pick_margin() | ($urandom_range(0, 1) << 11));
      if ($urandom_range(0, 2) != 0) program_reg(CFG_SCREEN_WIDTH, pick_size());
      if ($urandom_range(0, 2) != 0) program_reg(CFG_SCREEN_HEIGHT, pick_size());
      @(negedge clk_i);
      src_idle_on  = (phase < 13) && ($urandom_range(0, 3) != 0);
      sink_idle_on = (phase < 13) && ($urandom_range(0, 3) != 0);
      // Hold the output for a long stretch while samples keep coming, to back up the input.
      if (phase == 2) begin
        src_idle_on    = 1'b0;
        sink_hold_left = LONG_HOLD;
      end
      n = 82;
      repeat (n) queue_touch($urandom_range(0, 7) != 0, pick_coord(), pick_coord());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_points.size() != 0) begin
      $error("%0d mapped points never came out", expected_points.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS touch_coordinate_mapper");
    end else begin
      $display("FAIL touch_coordinate_mapper");
    end
    $finish;
  end

endmodule
